### sv/guaranteed_slot_allocator_top_assert.svh
// assertion macros used by the slot allocator checker
`ifndef GUARANTEED_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define GUARANTEED_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define GSA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define GSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/gsa_pkg.sv
// types, codes and constants of the guaranteed slot allocator
`default_nettype none

package gsa_pkg;

	// signed slot budget; covers the largest default table of seven 15-slot entries
	localparam int CAP_W = 10;

	// register reset values
	localparam logic [6:0]  TOTAL_SLOTS_RST  = 7'd16;
	localparam logic [9:0]  BASE_SLOT_RST    = 10'd60;
	localparam logic [15:0] MIN_CONT_RST     = 16'd440;
	localparam logic [3:0]  FRAME_ORDER_RST  = 4'd4;

	// request functions
	localparam logic FUNC_REQUEST = 1'b0;
	localparam logic FUNC_BEACON  = 1'b1;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_TOTAL_SLOTS  = 2'd0,
		REG_BASE_SLOT    = 2'd1,
		REG_MIN_CONT     = 2'd2,
		REG_FRAME_ORDER  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [6:0]  total_slots;
		logic [9:0]  base_slot_duration;
		logic [15:0] min_contention_length;
		logic [3:0]  frame_order;
	} cfg_t;

	// input word
	typedef struct packed {
		logic        func;
		logic [15:0] requester_id;
		logic [3:0]  request_length;
	} req_t;

	// result word
	typedef struct packed {
		logic [3:0]  granted_length;
		logic        entry_valid;
		logic [15:0] entry_owner;
		logic [3:0]  entry_length;
		logic [6:0]  entry_start;
		logic [6:0]  contention_length;
		logic        list_error;
		logic        last;
	} res_t;

	// one allocation table entry
	typedef struct packed {
		logic [3:0]  length;
		logic [15:0] owner;
	} ent_t;

	// datapath commands
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_REQ_STEP,
		OP_REQ_SAME,
		OP_REQ_MUL,
		OP_REQ_DECIDE,
		OP_BCN_STEP,
		OP_BCN_ERROR,
		OP_BCN_EMPTY,
		OP_BCN_RESTART,
		OP_BCN_EMIT
	} op_t;

	// datapath status
	typedef struct packed {
		logic walk_done;
		logic hit;
		logic same_len;
		logic fits;
		logic last_entry;
		logic empty;
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REQ_WALK,
		ST_REQ_DECIDE,
		ST_BCN_CHECK,
		ST_BCN_EMIT
	} state_t;

endpackage

`default_nettype wire

### sv/gsa_cfg.sv
// configuration registers of the slot allocator
`default_nettype none

module gsa_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [15:0]   cfg_data,
	output gsa_pkg::cfg_t      cfg
);
	import gsa_pkg::*;

	cfg_t cfg_q;

	// register writes, values masked to width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total_slots           <= TOTAL_SLOTS_RST;
			cfg_q.base_slot_duration    <= BASE_SLOT_RST;
			cfg_q.min_contention_length <= MIN_CONT_RST;
			cfg_q.frame_order           <= FRAME_ORDER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOTAL_SLOTS: cfg_q.total_slots           <= cfg_data[6:0];
				REG_BASE_SLOT:   cfg_q.base_slot_duration    <= cfg_data[9:0];
				REG_MIN_CONT:    cfg_q.min_contention_length <= cfg_data;
				REG_FRAME_ORDER: cfg_q.frame_order           <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### sv/gsa_ctrl.sv
// sequencing state machine of the slot allocator
`default_nettype none

module gsa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          func,
	input  wire gsa_pkg::status_t status,
	output gsa_pkg::op_t       op,
	output logic               busy
);
	import gsa_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op      = OP_LOAD;
					state_d = (func == FUNC_BEACON) ? ST_BCN_CHECK : ST_REQ_WALK;
				end
			end
			ST_REQ_WALK: begin
				if (status.walk_done) begin
					op      = OP_REQ_MUL;
					state_d = ST_REQ_DECIDE;
				end else if (status.hit && status.same_len) begin
					op      = OP_REQ_SAME;
					state_d = ST_IDLE;
				end else begin
					op = OP_REQ_STEP;
				end
			end
			ST_REQ_DECIDE: begin
				op      = OP_REQ_DECIDE;
				state_d = ST_IDLE;
			end
			ST_BCN_CHECK: begin
				if (status.walk_done) begin
					if (status.empty) begin
						op      = OP_BCN_EMPTY;
						state_d = ST_IDLE;
					end else begin
						op      = OP_BCN_RESTART;
						state_d = ST_BCN_EMIT;
					end
				end else if (status.fits) begin
					op = OP_BCN_STEP;
				end else begin
					op      = OP_BCN_ERROR;
					state_d = ST_IDLE;
				end
			end
			ST_BCN_EMIT: begin
				op = OP_BCN_EMIT;
				if (status.last_entry) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### sv/gsa_datapath.sv
// allocation table, slot budget arithmetic and result register
`default_nettype none

module gsa_datapath #(
	parameter int MAX_ALLOCATIONS = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire gsa_pkg::op_t  op,
	input  wire gsa_pkg::req_t cmd,
	input  wire gsa_pkg::cfg_t cfg,
	output gsa_pkg::status_t   status,
	output gsa_pkg::res_t      res,
	output logic               res_strobe
);
	import gsa_pkg::*;

	localparam int CNT_W = $clog2(MAX_ALLOCATIONS + 1);

	ent_t                    tbl_q [MAX_ALLOCATIONS];
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        idx_q;
	logic [15:0]             id_q;
	logic [3:0]              len_q;
	logic signed [CAP_W-1:0] cap_q;
	logic [6:0]              run_q;
	logic [16:0]             prod_q;
	logic                    neg_q;
	res_t                    res_q;
	logic                    strobe_q;

	ent_t                    cur;
	logic signed [CAP_W-1:0] cur_len_s;
	logic signed [CAP_W-1:0] cap_sub;
	logic signed [CAP_W-1:0] diff;
	logic [6:0]              run_sub;
	logic [7:0]              start_full;
	logic [31:0]             room;
	logic                    refuse;
	logic                    emit;
	res_t                    res_d;

	// entry under the walk index
	always_comb begin
		cur = '0;
		for (int k = 0; k < MAX_ALLOCATIONS; k++) begin
			if (CNT_W'(k) == idx_q) begin
				cur = tbl_q[k];
			end
		end
	end

	// budget arithmetic
	assign cur_len_s  = $signed({{(CAP_W-4){1'b0}}, cur.length});
	assign cap_sub    = cap_q - cur_len_s;
	assign diff       = cap_q - $signed({{(CAP_W-4){1'b0}}, len_q});
	assign run_sub    = run_q - {3'b000, cur.length};
	assign start_full = {1'b0, run_sub} + 8'd1;
	assign room       = {15'b0, prod_q} << cfg.frame_order;
	assign refuse     = (count_q >= CNT_W'(MAX_ALLOCATIONS)) || neg_q
	                    || (room < {16'b0, cfg.min_contention_length});

	// status to the controller
	assign status.walk_done  = (idx_q >= count_q);
	assign status.hit        = (cur.owner == id_q);
	assign status.same_len   = (cur.length == len_q);
	assign status.fits       = (cap_q > cur_len_s);
	assign status.last_entry = (({1'b0, idx_q} + (CNT_W+1)'(1)) == {1'b0, count_q});
	assign status.empty      = (count_q == '0);

	// result word for each emitting command
	always_comb begin
		res_d = '0;
		emit  = 1'b0;
		case (op)
			OP_REQ_SAME: begin
				emit                 = 1'b1;
				res_d.granted_length = len_q;
				res_d.last           = 1'b1;
			end
			OP_REQ_DECIDE: begin
				emit                 = 1'b1;
				res_d.granted_length = refuse ? 4'd0 : len_q;
				res_d.last           = 1'b1;
			end
			OP_BCN_ERROR: begin
				emit                    = 1'b1;
				res_d.contention_length = cfg.total_slots;
				res_d.list_error        = 1'b1;
				res_d.last              = 1'b1;
			end
			OP_BCN_EMPTY: begin
				emit                    = 1'b1;
				res_d.contention_length = cfg.total_slots;
				res_d.last              = 1'b1;
			end
			OP_BCN_EMIT: begin
				emit                    = 1'b1;
				res_d.entry_valid       = 1'b1;
				res_d.entry_owner       = cur.owner;
				res_d.entry_length      = cur.length;
				res_d.entry_start       = start_full[7] ? 7'd127 : start_full[6:0];
				res_d.contention_length = cap_q[6:0];
				res_d.last              = status.last_entry;
			end
			default: ;
		endcase
	end

	// fill count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			case (op)
				OP_REQ_STEP: begin
					if (status.hit) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				OP_REQ_DECIDE: begin
					if (!refuse) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_BCN_ERROR: count_q <= '0;
				default: ;
			endcase
		end
	end

	// table, walk registers and result word
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
		case (op)
			OP_LOAD: begin
				id_q  <= cmd.requester_id;
				len_q <= cmd.request_length;
				idx_q <= '0;
				cap_q <= $signed({{(CAP_W-7){1'b0}}, cfg.total_slots});
			end
			OP_REQ_STEP: begin
				if (status.hit) begin
					// close the gap, keeping table order
					for (int k = 0; k < MAX_ALLOCATIONS - 1; k++) begin
						if (CNT_W'(k) >= idx_q) begin
							tbl_q[k] <= tbl_q[k+1];
						end
					end
				end else begin
					cap_q <= cap_sub;
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			OP_REQ_MUL: begin
				neg_q  <= diff[CAP_W-1];
				prod_q <= {10'b0, diff[6:0]} * {7'b0, cfg.base_slot_duration};
			end
			OP_REQ_DECIDE: begin
				if (!refuse) begin
					for (int k = 0; k < MAX_ALLOCATIONS; k++) begin
						if (CNT_W'(k) == count_q) begin
							tbl_q[k] <= '{length: len_q, owner: id_q};
						end
					end
				end
			end
			OP_BCN_STEP: begin
				cap_q <= cap_sub;
				idx_q <= idx_q + CNT_W'(1);
			end
			OP_BCN_RESTART: begin
				idx_q <= '0;
				run_q <= cfg.total_slots;
			end
			OP_BCN_EMIT: begin
				run_q <= run_sub;
				idx_q <= idx_q + CNT_W'(1);
			end
			default: ;
		endcase
	end

	assign res        = res_q;
	assign res_strobe = strobe_q;

endmodule

`default_nettype wire

### sv/guaranteed_slot_allocator_top.sv
// Guaranteed slot allocator, coordinator side. A word is taken when start is
// high and busy is low; func 0 is a slot request, func 1 prepares the beacon
// list. Results leave on res, each for exactly one cycle under res_strobe, and
// the receiver cannot stall them. A request walks the table one entry per
// cycle, a removal of a changed entry holding it in place; a same-length
// hit ends it, else the budget multiply is registered and the admission
// decision made, each path giving a single result. A beacon walks the table
// once to check the budget and find the contention length, then emits one
// entry per cycle in consecutive cycles; an overrun or an empty table gives
// one bare result. busy falls when the last result is loaded, so the next
// word may start while it shows. Configuration must be written through
// cfg_we, cfg_index and cfg_data while idle; the block does not enforce it.
`default_nettype none

module guaranteed_slot_allocator_top #(
	parameter int MAX_ALLOCATIONS = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire gsa_pkg::req_t cmd,
	output gsa_pkg::res_t      res,
	output logic               res_strobe,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [15:0]   cfg_data
);
	import gsa_pkg::*;

	cfg_t    cfg;
	op_t     op;
	status_t status;

	// configuration registers
	gsa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// controller
	gsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (cmd.func),
		.status (status),
		.op     (op),
		.busy   (busy)
	);

	// datapath
	gsa_datapath #(
		.MAX_ALLOCATIONS (MAX_ALLOCATIONS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.cmd        (cmd),
		.cfg        (cfg),
		.status     (status),
		.res        (res),
		.res_strobe (res_strobe)
	);

endmodule

`default_nettype wire

### sv/gsa_checker.sv
// port-level checks of the slot allocator and their binding
`default_nettype none

`include "guaranteed_slot_allocator_top_assert.svh"

module gsa_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          busy,
	input  wire logic          res_strobe,
	input  wire gsa_pkg::res_t res
);
	import gsa_pkg::*;

	// an accepted word keeps the block busy in the next cycle
	`GSA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")

	// a result without an entry is the only result of its word
	`GSA_ASSERT_NOW(a_bare_last, res_strobe && !res.entry_valid, res.last, "bare result not last")

	// an overrun result carries no entry and no grant
	`GSA_ASSERT_NOW(a_err_clean, res_strobe && res.list_error, !res.entry_valid && res.granted_length == 4'd0, "overrun result not clean")

	// beacon entries leave in consecutive cycles
	`GSA_ASSERT_NEXT(a_entry_burst, res_strobe && res.entry_valid && !res.last, res_strobe && res.entry_valid, "beacon entries not back to back")

endmodule

bind guaranteed_slot_allocator_top gsa_checker u_gsa_checker (.*);

`default_nettype wire
